// File: hdl/signal_false_colour_mixer_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the false colour mixer checker
// Each macro expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef SIGNAL_FALSE_COLOUR_MIXER_DEFINES_SVH
`define SIGNAL_FALSE_COLOUR_MIXER_DEFINES_SVH

// same-cycle implication
`define SFCM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfcm checker: same-cycle property failed");

// next-cycle implication
`define SFCM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfcm checker: next-cycle property failed");

`endif

// File: hdl/sfcm_pkg.sv
// ----------------------------------------------------------------------------
// sfcm_pkg
// Types, widths and register codes shared by the false colour mixer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfcm_pkg;

    localparam int NUM_SIGNALS = 4;   // signals accumulated per grid unit (1..4)
    localparam int NUM_SETUP   = 4;   // setup registers present
    localparam int SETUP_AW    = 2;
    localparam int POS_W       = 3;

    localparam int CONC_W   = 16;
    localparam int RECIP_W  = 16;
    localparam int RAW_W    = CONC_W + RECIP_W;
    localparam int LEVEL_W  = 17;
    localparam int TOTAL_W  = 19;
    localparam int COLOUR_W = 8;
    localparam int SUM_W    = 27;
    localparam int CPROD_W  = LEVEL_W + COLOUR_W;
    localparam int PROD_W   = SUM_W + LEVEL_W;
    localparam int PBG_W    = LEVEL_W + COLOUR_W;
    localparam int NUM_W    = PROD_W + 2;
    localparam int FRAC_W   = 16;
    localparam int DIV_W    = NUM_W - FRAC_W;
    localparam int DVS_W    = TOTAL_W + COLOUR_W;
    localparam int CNT_W    = 4;
    localparam int ROUND_SH = FRAC_W - 1;

    localparam logic [LEVEL_W-1:0] LEVEL_ONE = LEVEL_W'(1) << FRAC_W;

    localparam int QUEUE_AW    = 1;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    // configuration register indexes
    localparam int REG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;
    localparam logic [REG_IDX_W-1:0] REG_SIGNAL_0   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SIGNAL_1   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SIGNAL_2   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SIGNAL_3   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_BACKGROUND = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_MIN_LEVEL  = 3'd5;

    // colour channel codes in the mixer
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    typedef struct packed {
        logic [CONC_W-1:0] concentration;
        logic              last_signal;
    } in_item_t;

    typedef struct packed {
        logic [COLOUR_W-1:0] red;
        logic [COLOUR_W-1:0] green;
        logic [COLOUR_W-1:0] blue;
        logic                visible;
    } out_item_t;

    typedef struct packed {
        logic [RECIP_W-1:0]  recip;
        logic [COLOUR_W-1:0] red;
        logic [COLOUR_W-1:0] green;
        logic [COLOUR_W-1:0] blue;
    } signal_setup_t;

    typedef struct packed {
        logic [COLOUR_W-1:0] red;
        logic [COLOUR_W-1:0] green;
        logic [COLOUR_W-1:0] blue;
    } colour_t;

    // classified item handed from front to back
    typedef struct packed {
        logic                accumulate;
        logic                last;
        logic [LEVEL_W-1:0]  level;
        colour_t             colour;
    } q_entry_t;

    // accumulated unit handed to the mixer
    typedef struct packed {
        logic [LEVEL_W-1:0] peak;
        logic [TOTAL_W-1:0] total;
        logic [SUM_W-1:0]   red_sum;
        logic [SUM_W-1:0]   green_sum;
        logic [SUM_W-1:0]   blue_sum;
    } mix_job_t;

    typedef enum logic [2:0] {
        MIX_IDLE,
        MIX_MUL_A,
        MIX_MUL_B,
        MIX_ADD,
        MIX_DIV,
        MIX_OUT
    } mix_state_t;

endpackage

// File: hdl/sfcm_queue.sv
// ----------------------------------------------------------------------------
// sfcm_queue
// Two-entry queue between the classifier front and the accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfcm_queue
    import sfcm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push_valid,
    output logic     push_ready,
    input  q_entry_t push_entry,
    output logic     pop_valid,
    input  logic     pop_ready,
    output q_entry_t pop_entry
);

    q_entry_t              mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_AW:0]     count_reg;
    logic                  push;
    logic                  pop;

    assign push_ready = (count_reg != (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_entry;
    end

endmodule

// File: hdl/sfcm_front.sv
// ----------------------------------------------------------------------------
// sfcm_front
// Accepts items, tracks the signal position and computes the clamped level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfcm_front
    import sfcm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_ready,
    input  in_item_t      item,
    input  signal_setup_t setup [NUM_SETUP],
    output logic          push_valid,
    input  logic          push_ready,
    output q_entry_t      push_entry
);

    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic               accumulate;
    signal_setup_t      cur_setup;
    logic [RAW_W-1:0]   raw_level;
    logic [LEVEL_W-1:0] level;
    logic               take;

    assign accumulate = (pos_reg < POS_W'(NUM_SIGNALS));
    assign cur_setup  = setup[pos_reg[SETUP_AW-1:0]];
    assign raw_level  = item.concentration * cur_setup.recip;
    assign level      = (raw_level > RAW_W'(LEVEL_ONE)) ? LEVEL_ONE : raw_level[LEVEL_W-1:0];

    assign item_ready = push_ready;
    assign push_valid = item_valid;
    assign take       = item_valid && push_ready;

    always_comb
    begin
        push_entry.accumulate   = accumulate;
        push_entry.last         = item.last_signal;
        push_entry.level        = level;
        push_entry.colour.red   = cur_setup.red;
        push_entry.colour.green = cur_setup.green;
        push_entry.colour.blue  = cur_setup.blue;

        pos_next = pos_reg;
        if (take)
        begin
            if (item.last_signal)
                pos_next = '0;
            else if (accumulate)
                pos_next = pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else
            pos_reg <= pos_next;
    end

endmodule

// File: hdl/sfcm_accum.sv
// ----------------------------------------------------------------------------
// sfcm_accum
// Accumulates peak, total and weighted colour sums of one grid unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfcm_accum
    import sfcm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     pop_valid,
    output logic     pop_ready,
    input  q_entry_t pop_entry,
    output logic     job_valid,
    input  logic     job_ready,
    output mix_job_t job
);

    logic [LEVEL_W-1:0] peak_reg,  peak_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [SUM_W-1:0]   red_reg,   red_next;
    logic [SUM_W-1:0]   green_reg, green_next;
    logic [SUM_W-1:0]   blue_reg,  blue_next;
    logic               pending_reg, pending_next;
    logic [CPROD_W-1:0] red_prod, green_prod, blue_prod;
    logic               pop;

    // pop is held off while a finished unit waits for the mixer
    assign pop_ready = !pending_reg;
    assign pop       = pop_valid && !pending_reg;
    assign job_valid = pending_reg;

    assign red_prod   = pop_entry.level * pop_entry.colour.red;
    assign green_prod = pop_entry.level * pop_entry.colour.green;
    assign blue_prod  = pop_entry.level * pop_entry.colour.blue;

    assign job.peak      = peak_reg;
    assign job.total     = total_reg;
    assign job.red_sum   = red_reg;
    assign job.green_sum = green_reg;
    assign job.blue_sum  = blue_reg;

    always_comb
    begin
        peak_next    = peak_reg;
        total_next   = total_reg;
        red_next     = red_reg;
        green_next   = green_reg;
        blue_next    = blue_reg;
        pending_next = pending_reg;

        if (pop)
        begin
            if (pop_entry.accumulate)
            begin
                if (pop_entry.level > peak_reg)
                    peak_next = pop_entry.level;
                total_next = total_reg + TOTAL_W'(pop_entry.level);
                red_next   = red_reg + SUM_W'(red_prod);
                green_next = green_reg + SUM_W'(green_prod);
                blue_next  = blue_reg + SUM_W'(blue_prod);
            end
            if (pop_entry.last)
                pending_next = 1'b1;
        end
        else if (pending_reg && job_ready)
        begin
            peak_next    = '0;
            total_next   = '0;
            red_next     = '0;
            green_next   = '0;
            blue_next    = '0;
            pending_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg    <= '0;
            total_reg   <= '0;
            red_reg     <= '0;
            green_reg   <= '0;
            blue_reg    <= '0;
            pending_reg <= 1'b0;
        end
        else
        begin
            peak_reg    <= peak_next;
            total_reg   <= total_next;
            red_reg     <= red_next;
            green_reg   <= green_next;
            blue_reg    <= blue_next;
            pending_reg <= pending_next;
        end
    end

endmodule

// File: hdl/sfcm_mixer.sv
// ----------------------------------------------------------------------------
// sfcm_mixer
// Mixes one unit channel by channel: two multiply steps, one add, then a
// restoring divide by the total with an up-front saturation check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfcm_mixer
    import sfcm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    output logic               job_ready,
    input  mix_job_t           job,
    input  colour_t            background,
    input  logic [LEVEL_W-1:0] min_level,
    output logic               result_valid,
    input  logic               result_ready,
    output out_item_t          result
);

    mix_state_t          state_reg, state_next;
    logic [1:0]          ch_reg, ch_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    mix_job_t            job_reg, job_next;
    out_item_t           res_reg, res_next;
    logic [PROD_W-1:0]   prod_a_reg, prod_a_next;
    logic [PROD_W-1:0]   prod_b_reg, prod_b_next;
    logic [PBG_W-1:0]    pbg_reg, pbg_next;
    logic [DIV_W-1:0]    rem_reg, rem_next;
    logic [DVS_W-1:0]    dvs_reg, dvs_next;
    logic [COLOUR_W-1:0] q_reg, q_next;

    logic [SUM_W-1:0]    sum_sel;
    logic [COLOUR_W-1:0] bg_sel;
    logic [LEVEL_W-1:0]  inv_peak;
    logic [NUM_W-1:0]    num;
    logic                ge;
    logic                byte_done;
    logic [COLOUR_W-1:0] byte_val;

    assign inv_peak = LEVEL_ONE - job_reg.peak;
    assign num      = NUM_W'(prod_a_reg) + NUM_W'(prod_b_reg)
                    + (NUM_W'(job_reg.total) << ROUND_SH);
    assign ge       = (rem_reg >= DIV_W'(dvs_reg));
    assign result   = res_reg;

    always_comb
    begin
        case (ch_reg)
            CH_RED:
            begin
                sum_sel = job_reg.red_sum;
                bg_sel  = background.red;
            end
            CH_GREEN:
            begin
                sum_sel = job_reg.green_sum;
                bg_sel  = background.green;
            end
            default:
            begin
                sum_sel = job_reg.blue_sum;
                bg_sel  = background.blue;
            end
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        ch_next      = ch_reg;
        cnt_next     = cnt_reg;
        job_next     = job_reg;
        res_next     = res_reg;
        prod_a_next  = prod_a_reg;
        prod_b_next  = prod_b_reg;
        pbg_next     = pbg_reg;
        rem_next     = rem_reg;
        dvs_next     = dvs_reg;
        q_next       = q_reg;
        job_ready    = 1'b0;
        result_valid = 1'b0;
        byte_done    = 1'b0;
        byte_val     = q_reg;

        case (state_reg)
            MIX_IDLE:
            begin
                job_ready = 1'b1;
                if (job_valid)
                begin
                    job_next         = job;
                    ch_next          = CH_RED;
                    res_next         = '0;
                    res_next.visible = (job.peak > min_level);
                    // below threshold: all channels stay zero
                    state_next       = (job.peak > min_level) ? MIX_MUL_A : MIX_OUT;
                end
            end
            MIX_MUL_A:
            begin
                prod_a_next = sum_sel * job_reg.peak;
                pbg_next    = inv_peak * bg_sel;
                state_next  = MIX_MUL_B;
            end
            MIX_MUL_B:
            begin
                prod_b_next = pbg_reg * job_reg.total;
                state_next  = MIX_ADD;
            end
            MIX_ADD:
            begin
                // dropping the fraction first leaves the integer quotient unchanged
                rem_next   = num[NUM_W-1:FRAC_W];
                dvs_next   = {job_reg.total, {COLOUR_W{1'b0}}};
                cnt_next   = CNT_W'(COLOUR_W);
                q_next     = '0;
                state_next = MIX_DIV;
            end
            MIX_DIV:
            begin
                dvs_next = dvs_reg >> 1;
                if (cnt_reg == CNT_W'(COLOUR_W))
                begin
                    // quotient of 256 or more saturates
                    if (ge)
                    begin
                        byte_done = 1'b1;
                        byte_val  = '1;
                    end
                    else
                        cnt_next = cnt_reg - 1'b1;
                end
                else
                begin
                    if (ge)
                        rem_next = rem_reg - DIV_W'(dvs_reg);
                    q_next = {q_reg[COLOUR_W-2:0], ge};
                    if (cnt_reg == '0)
                    begin
                        byte_done = 1'b1;
                        byte_val  = {q_reg[COLOUR_W-2:0], ge};
                    end
                    else
                        cnt_next = cnt_reg - 1'b1;
                end

                if (byte_done)
                begin
                    case (ch_reg)
                        CH_RED:   res_next.red   = byte_val;
                        CH_GREEN: res_next.green = byte_val;
                        default:  res_next.blue  = byte_val;
                    endcase
                    if (ch_reg == CH_BLUE)
                        state_next = MIX_OUT;
                    else
                    begin
                        ch_next    = ch_reg + 1'b1;
                        state_next = MIX_MUL_A;
                    end
                end
            end
            MIX_OUT:
            begin
                result_valid = 1'b1;
                if (result_ready)
                    state_next = MIX_IDLE;
            end
            default:
            begin
                state_next = MIX_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MIX_IDLE;
            ch_reg    <= CH_RED;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg    <= job_next;
        res_reg    <= res_next;
        prod_a_reg <= prod_a_next;
        prod_b_reg <= prod_b_next;
        pbg_reg    <= pbg_next;
        rem_reg    <= rem_next;
        dvs_reg    <= dvs_next;
        q_reg      <= q_next;
    end

endmodule

// File: hdl/signal_false_colour_mixer.sv
// ----------------------------------------------------------------------------
// signal_false_colour_mixer
// False colour mixer: blends up to four signal levels of a grid unit into RGB.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid/item_ready/item) carries one signal concentration
//   per transaction, in signal order; last_signal closes the grid unit.
//   result channel (result_valid/result_ready/result) carries one mixed
//   colour transaction per closed unit. Configuration writes (cfg_we,
//   cfg_index, cfg_data) are registered; the user must make them while the
//   block idles, though the block itself does not enforce this.
//   Throughput: items enter at one per cycle while the two-entry queue has
//   room; the accumulator retires one per cycle while no closed unit waits
//   for the mixer. Per channel the mixer passes its MIX_MUL_A, MIX_MUL_B and
//   MIX_ADD states, then 9 divide steps (1 when it saturates); it loads the
//   job in MIX_IDLE and offers the result in MIX_OUT. While the mixer works
//   on one unit, the accumulator gathers the next. A unit below threshold
//   goes from MIX_IDLE straight to MIX_OUT.
//   Reset: configuration clears to zero, accumulators and queue empty.
//   Stall: a held result keeps the mixer busy; the accumulator and queue
//   keep filling, and item_ready drops once the queue is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module signal_false_colour_mixer
    import sfcm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  in_item_t              item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output out_item_t             result,
    input  logic                  cfg_we,
    input  logic [REG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration registers
    signal_setup_t      setup_reg [NUM_SETUP];
    colour_t            bg_reg;
    logic [LEVEL_W-1:0] min_level_reg;

    // front -> queue -> accumulator -> mixer
    logic     push_valid, push_ready;
    q_entry_t push_entry;
    logic     pop_valid, pop_ready;
    q_entry_t pop_entry;
    logic     job_valid, job_ready;
    mix_job_t job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SETUP; i++)
                setup_reg[i] <= '0;
            bg_reg        <= '0;
            min_level_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SIGNAL_0, REG_SIGNAL_1, REG_SIGNAL_2, REG_SIGNAL_3:
                    setup_reg[cfg_index[SETUP_AW-1:0]] <= signal_setup_t'(cfg_data);
                REG_BACKGROUND:
                    bg_reg <= colour_t'(cfg_data[3*COLOUR_W-1:0]);
                REG_MIN_LEVEL:
                    min_level_reg <= cfg_data[LEVEL_W-1:0];
                default:
                    ;   // unmapped index, write dropped
            endcase
        end
    end

    // classify: position tracking and level = min(conc * recip, 1.0)
    sfcm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .setup      (setup_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    sfcm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    // peak, total and weighted sums; hands a closed unit to the mixer
    sfcm_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    // per channel: (sum*P + (1-P)*bg*T + T/2) / T, saturated to 8 bits
    sfcm_mixer u_mixer (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (job_valid),
        .job_ready    (job_ready),
        .job          (job),
        .background   (bg_reg),
        .min_level    (min_level_reg),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// File: hdl/sfcm_checker.sv
// ----------------------------------------------------------------------------
// sfcm_checker
// Port-level checks on the false colour mixer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "signal_false_colour_mixer_defines.svh"

module sfcm_checker
    import sfcm_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      item_valid,
    input logic      item_ready,
    input in_item_t  item,
    input logic      result_valid,
    input logic      result_ready,
    input out_item_t result
);

    // closed units not yet delivered
    logic [3:0] open_reg, open_next;
    logic       unit_in, unit_out;
    logic       rgb_zero, res_hold;

    assign unit_in  = item_valid && item_ready && item.last_signal;
    assign unit_out = result_valid && result_ready;
    assign rgb_zero = (result.red == '0) && (result.green == '0) && (result.blue == '0);
    assign res_hold = result_valid && !result_ready;

    always_comb
    begin
        open_next = open_reg;
        if (unit_in && !unit_out)
            open_next = open_reg + 1'b1;
        else if (unit_out && !unit_in)
            open_next = open_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            open_reg <= '0;
        else
            open_reg <= open_next;
    end

    `SFCM_ASSERT_NOW(a_result_has_unit, result_valid, open_reg != 4'd0)

    // queue (2) + accumulator (1) + mixer (1)
    `SFCM_ASSERT_NOW(a_units_bounded, 1'b1, open_reg <= 4'd4)

    `SFCM_ASSERT_NOW(a_hidden_is_black, result_valid && !result.visible, rgb_zero)

    `SFCM_ASSERT_NEXT(a_result_held, res_hold, result_valid && $stable(result))

endmodule

bind signal_false_colour_mixer sfcm_checker u_sfcm_checker (.*);

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: false colour mixer testbench
// Streams grid units of signal concentrations through the mixer and checks
// every mixed colour against a cycle-free model kept inside the bench. The
// run walks through several register settings, starting from the reset one,
// with random gaps on the item side and random stalls on the result side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import sfcm_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 10;
    localparam int ITEM_TARGET  = 1800;
    localparam int PHASE_ITEMS  = 150;
    localparam int IDLE_WAIT    = 64;
    localparam int CYCLE_LIMIT  = 800000;
    localparam int SHOW_MAX     = 10;

    // ------------------------------------------------------------------
    // DUT connections, all inputs known from time zero
    // ------------------------------------------------------------------
    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  item_valid   = 1'b0;
    logic                  item_ready;
    in_item_t              item_pl      = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    out_item_t             result_pl;
    logic                  cfg_we       = 1'b0;
    logic [REG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    signal_false_colour_mixer u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item_pl),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result_pl),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------
    // Bench-side copy of the registers and of the unit accumulator
    // ------------------------------------------------------------------
    signal_setup_t      cfg_setup [NUM_SETUP];
    colour_t            cfg_bg  = '0;
    logic [LEVEL_W-1:0] cfg_min = '0;

    logic [POS_W-1:0]   acc_pos   = '0;
    logic [LEVEL_W-1:0] acc_peak  = '0;
    logic [TOTAL_W-1:0] acc_total = '0;
    logic [SUM_W-1:0]   acc_red   = '0;
    logic [SUM_W-1:0]   acc_green = '0;
    logic [SUM_W-1:0]   acc_blue  = '0;

    in_item_t  pending_items [$];     // items waiting for the driver
    out_item_t expected_colours [$];  // predicted results, oldest first

    int  cycle_count     = 0;
    int  mismatch_count  = 0;
    int  results_checked = 0;
    int  visible_seen    = 0;
    int  items_counted   = 0;
    int  phase_count     = 0;
    int  unit_pos        = 0;         // position of next queued item in its unit
    logic item_took      = 1'b0;      // item transaction at the last rising edge
    int  gap_left        = 0;
    int  hold_left       = 0;
    logic calm_in        = 1'b0;      // stretches without any idling
    logic calm_out       = 1'b0;

    initial begin
        for (int i = 0; i < NUM_SETUP; i++)
            cfg_setup[i] = '0;
    end

    // one channel: (sum * P + (1 - P) * bg * T + T / 2) / T, saturated
    function automatic logic [COLOUR_W-1:0] blend_channel(input logic [SUM_W-1:0] sum,
                                                          input logic [COLOUR_W-1:0] bgc);
        logic [63:0] t, p, num, den, q;
        t   = 64'(acc_total);
        p   = 64'(acc_peak);
        den = t << FRAC_W;
        num = 64'(sum) * p + (64'(LEVEL_ONE) - p) * 64'(bgc) * t + t * 64'd32768;
        if (den == 0)
            return '0;
        q = num / den;
        return (q > 64'd255) ? 8'd255 : q[COLOUR_W-1:0];
    endfunction

    // Accumulates one accepted item; returns 1 and the mixed colour when
    // the item closes its grid unit.
    function automatic logic mix_step(input in_item_t it, output out_item_t res);
        signal_setup_t      s;
        logic [31:0]        raw;
        logic [LEVEL_W-1:0] lvl;
        res = '0;
        // items past the last signal slot are dropped, but a last flag still counts
        if (acc_pos < NUM_SIGNALS) begin
            s   = cfg_setup[acc_pos[SETUP_AW-1:0]];
            raw = 32'(it.concentration) * 32'(s.recip);
            lvl = (raw > 32'(LEVEL_ONE)) ? LEVEL_ONE : raw[LEVEL_W-1:0];
            if (lvl > acc_peak)
                acc_peak = lvl;
            acc_total = acc_total + TOTAL_W'(lvl);
            acc_red   = acc_red   + SUM_W'(lvl) * SUM_W'(s.red);
            acc_green = acc_green + SUM_W'(lvl) * SUM_W'(s.green);
            acc_blue  = acc_blue  + SUM_W'(lvl) * SUM_W'(s.blue);
            acc_pos   = acc_pos + 1'b1;
        end
        if (!it.last_signal)
            return 1'b0;
        // below threshold (this includes the all-zero unit): black, not visible
        if (acc_peak > cfg_min && acc_total != 0) begin
            res.red     = blend_channel(acc_red,   cfg_bg.red);
            res.green   = blend_channel(acc_green, cfg_bg.green);
            res.blue    = blend_channel(acc_blue,  cfg_bg.blue);
            res.visible = 1'b1;
        end
        acc_pos   = '0;
        acc_peak  = '0;
        acc_total = '0;
        acc_red   = '0;
        acc_green = '0;
        acc_blue  = '0;
        return 1'b1;
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------
    // Item driver: changes on the falling edge, holds until the transaction
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (!rst_n) begin
            item_valid <= 1'b0;
        end else if (!item_valid || item_took) begin
            if ($urandom_range(0, 199) == 0)
                calm_in = ~calm_in;
            if (gap_left > 0) begin
                item_valid <= 1'b0;
                gap_left--;
            end else if (pending_items.size() > 0) begin
                item_pl    <= pending_items.pop_front();
                item_valid <= 1'b1;
                gap_left   = calm_in ? 0 : pick_gap();
            end else begin
                item_valid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(negedge clk) begin
        if (!rst_n) begin
            result_ready <= 1'b0;
        end else begin
            if ($urandom_range(0, 199) == 0)
                calm_out = ~calm_out;
            if (hold_left > 0) begin
                result_ready <= 1'b0;
                hold_left--;
            end else begin
                result_ready <= 1'b1;
                if (!calm_out && $urandom_range(0, 4) == 0)
                    hold_left = pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on each item transaction, checks each result
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        out_item_t predicted, want;
        if (rst_n) begin
            item_took <= item_valid && item_ready;
            if (item_valid && item_ready) begin
                if (mix_step(item_pl, predicted))
                    expected_colours = {expected_colours, predicted};
            end
            if (result_valid && result_ready) begin
                if (expected_colours.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= SHOW_MAX)
                        $display("unexpected result r=%0d g=%0d b=%0d vis=%0b",
                                 result_pl.red, result_pl.green, result_pl.blue,
                                 result_pl.visible);
                end else begin
                    want = expected_colours.pop_front();
                    results_checked++;
                    if (want.visible)
                        visible_seen++;
                    if (result_pl.red !== want.red || result_pl.green !== want.green ||
                        result_pl.blue !== want.blue || result_pl.visible !== want.visible) begin
                        mismatch_count++;
                        if (mismatch_count <= SHOW_MAX) begin
                            $write("mismatch at result %0d: exp r=%0d g=%0d b=%0d vis=%0b, ",
                                   results_checked, want.red, want.green, want.blue,
                                   want.visible);
                            $display("got r=%0d g=%0d b=%0d vis=%0b",
                                     result_pl.red, result_pl.green,
                                     result_pl.blue, result_pl.visible);
                        end
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_colours.size());
            $display("tb: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_SIGNAL_0, REG_SIGNAL_1, REG_SIGNAL_2, REG_SIGNAL_3:
                cfg_setup[idx[SETUP_AW-1:0]] = val;
            REG_BACKGROUND: cfg_bg  = val[3*COLOUR_W-1:0];
            REG_MIN_LEVEL:  cfg_min = val[LEVEL_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_all(input signal_setup_t s0, input signal_setup_t s1,
                             input signal_setup_t s2, input signal_setup_t s3,
                             input colour_t bg, input logic [LEVEL_W-1:0] min_lvl);
        write_reg(REG_SIGNAL_0, CFG_DATA_W'(s0));
        write_reg(REG_SIGNAL_1, CFG_DATA_W'(s1));
        write_reg(REG_SIGNAL_2, CFG_DATA_W'(s2));
        write_reg(REG_SIGNAL_3, CFG_DATA_W'(s3));
        write_reg(REG_BACKGROUND, CFG_DATA_W'(bg));
        write_reg(REG_MIN_LEVEL, CFG_DATA_W'(min_lvl));
        phase_count++;
        @(posedge clk);
        #1;
    endtask

    // only items that reach a signal slot or close a unit are counted
    task automatic push_item(input logic [CONC_W-1:0] conc, input logic last);
        in_item_t it;
        it.concentration = conc;
        it.last_signal   = last;
        pending_items = {pending_items, it};
        if (unit_pos < NUM_SIGNALS || last)
            items_counted++;
        unit_pos = last ? 0 : unit_pos + 1;
    endtask

    // wait for all results, then let a unit still in the pipe settle
    task automatic drain();
        do begin
            @(posedge clk);
            #1;
        end while (pending_items.size() != 0 || item_valid || expected_colours.size() != 0);
        repeat (IDLE_WAIT) @(posedge clk);
    endtask

    function automatic logic [CONC_W-1:0] rand_conc();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        if (r < 4)
            return CONC_W'($urandom);
        return CONC_W'($urandom_range(0, 16'h0300));
    endfunction

    function automatic logic [COLOUR_W-1:0] rand_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return COLOUR_W'($urandom);
    endfunction

    function automatic signal_setup_t rand_setup();
        signal_setup_t s;
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            s.recip = '0;
        else if (r == 1)
            s.recip = '1;
        else if (r < 4)
            s.recip = RECIP_W'($urandom);
        else
            s.recip = RECIP_W'($urandom_range(16'h0040, 16'h0400));
        s.red   = rand_byte();
        s.green = rand_byte();
        s.blue  = rand_byte();
        return s;
    endfunction

    function automatic logic [LEVEL_W-1:0] rand_min();
        int r;
        r = $urandom_range(0, 19);
        if (r < 3)
            return '0;
        if (r < 5)
            return LEVEL_ONE;
        if (r == 5)
            return LEVEL_ONE - 1'b1;
        return LEVEL_W'($urandom_range(0, 40000));
    endfunction

    // mostly well-formed units, some overlong, a little loose noise
    task automatic push_unit();
        int r, len;
        r = $urandom_range(0, 99);
        if (r < 85) begin
            len = $urandom_range(1, NUM_SIGNALS);
            for (int k = 0; k < len; k++)
                push_item(rand_conc(), k == len - 1);
        end else if (r < 95) begin
            len = $urandom_range(NUM_SIGNALS + 1, NUM_SIGNALS + 3);
            for (int k = 0; k < len; k++)
                push_item(rand_conc(), k == len - 1);
        end else begin
            for (int k = 0; k < 3; k++)
                push_item(rand_conc(), $urandom_range(0, 2) == 0);
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        signal_setup_t s_max, s_zero;
        int phase_start, flavor;
        s_max  = '1;
        s_zero = '0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        #1;

        // reset settings: every reciprocal is zero, nothing can be visible
        push_item(16'h0100, 1'b1);
        push_item(16'hFFFF, 1'b0);
        push_item(16'hFFFF, 1'b1);
        drain();

        // primaries with unit gain, one huge gain, one half gain
        write_all({16'h0100, 8'hFF, 8'h00, 8'h00}, {16'h0100, 8'h00, 8'hFF, 8'h00},
                  {16'hFFFF, 8'h00, 8'h00, 8'hFF}, {16'h0080, 8'hFF, 8'hFF, 8'hFF},
                  24'h102030, '0);
        push_item(16'h0100, 1'b1);              // level exactly 1.0
        push_item(16'h0000, 1'b1);              // all-zero unit
        push_item(16'h0080, 1'b0);              // full four-signal unit, clamp on third
        push_item(16'h0040, 1'b0);
        push_item(16'hFFFF, 1'b0);
        push_item(16'h0200, 1'b1);
        push_item(16'h0010, 1'b0);              // overlong unit, last on a dropped item
        push_item(16'h0020, 1'b0);
        push_item(16'h0030, 1'b0);
        push_item(16'h0040, 1'b0);
        push_item(16'h0050, 1'b0);
        push_item(16'hFFFF, 1'b1);
        push_item(16'h0001, 1'b1);              // smallest nonzero level
        drain();

        // threshold boundary: peak equal to min_level stays hidden
        write_all({16'h0100, 8'h80, 8'h40, 8'h20}, s_max, s_max, s_max, 24'hFFFFFF, 17'h08000);
        push_item(16'h0080, 1'b1);
        push_item(16'h0081, 1'b1);
        drain();

        // min_level at 1.0: never visible
        write_all(s_max, s_max, s_max, s_max, 24'hFFFFFF, LEVEL_ONE);
        push_item(16'hFFFF, 1'b1);
        push_item(16'h0100, 1'b0);
        push_item(16'h0100, 1'b1);
        drain();

        // random phases; the first pins every register to an extreme, the second all but two signal setups
        flavor = 0;
        while (items_counted < ITEM_TARGET) begin
            if (flavor == 0)
                write_all(s_max, s_max, s_max, s_max, 24'hFFFFFF, '0);
            else if (flavor == 1)
                write_all(s_zero, rand_setup(), s_max, rand_setup(), 24'h000000, '0);
            else
                write_all(rand_setup(), rand_setup(), rand_setup(), rand_setup(),
                          {rand_byte(), rand_byte(), rand_byte()}, rand_min());
            flavor++;
            phase_start = items_counted;
            while (items_counted - phase_start < PHASE_ITEMS)
                push_unit();
            if (unit_pos != 0)
                push_item(rand_conc(), 1'b1);   // close a unit left open by noise
            drain();
        end

        $display("covered %0d counted items over %0d register settings", items_counted,
                 phase_count + 1);
        $display("checked %0d mixed colours, %0d visible, %0d mismatches", results_checked,
                 visible_seen, mismatch_count);
        if (mismatch_count == 0 && expected_colours.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+hdl
hdl/sfcm_pkg.sv
hdl/sfcm_queue.sv
hdl/sfcm_front.sv
hdl/sfcm_accum.sv
hdl/sfcm_mixer.sv
hdl/signal_false_colour_mixer.sv
hdl/sfcm_checker.sv
tb/sv/tb.sv
